// ===== sv/raycast_wall_texture_span_core_defines.svh =====
// Assertion macros for the wall texture span core.
`ifndef RAYCAST_WALL_TEXTURE_SPAN_CORE_DEFINES_SVH
`define RAYCAST_WALL_TEXTURE_SPAN_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RWTS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rwts implication check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define RWTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rwts next-cycle check failed");

`endif

// ===== sv/rwts_pkg.sv =====
// Constants and codes shared by the wall texture span core and its channels.
package rwts_pkg;

   localparam int TEXTURE_SIZE = 64;
   localparam int TEX_BITS     = $clog2(TEXTURE_SIZE);
   localparam int SCREEN_ROWS  = 768;
   localparam int HALF_ROWS    = SCREEN_ROWS / 2;

   // Step numerator TEXTURE_SIZE * 2^16 and the quotient width it needs.
   localparam int DIV_BITS = TEX_BITS + 17;
   localparam logic [DIV_BITS-1:0] DIVIDEND = DIV_BITS'(TEXTURE_SIZE) << 16;
   localparam int DIV_CNT_W = $clog2(DIV_BITS);

   // Shared multiplier operand widths (signed).
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic KIND_SETUP = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   localparam logic SIDE_X = 1'b0;
   localparam logic SIDE_Y = 1'b1;

   localparam logic [1:0] TEX_X_NEG = 2'd0;
   localparam logic [1:0] TEX_X_POS = 2'd1;
   localparam logic [1:0] TEX_Y_NEG = 2'd2;
   localparam logic [1:0] TEX_Y_POS = 2'd3;

endpackage

// ===== sv/rwts_req_if.sv =====
// Column-setup and pixel-tick input channel.
interface rwts_req_if
   import rwts_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               kind;
   logic               side;
   logic [23:0]        pos_x;
   logic [23:0]        pos_y;
   logic signed [17:0] ray_dir_x;
   logic signed [17:0] ray_dir_y;
   logic [23:0]        wall_distance;
   logic [15:0]        wall_height;
   logic [9:0]         span_start;
   logic [10:0]        span_end;

   modport source (output valid, kind, side, pos_x, pos_y, ray_dir_x, ray_dir_y,
                   wall_distance, wall_height, span_start, span_end, input ready);
   modport sink   (input valid, kind, side, pos_x, pos_y, ray_dir_x, ray_dir_y,
                   wall_distance, wall_height, span_start, span_end, output ready);
endinterface

// ===== sv/rwts_rsp_if.sv =====
// Texel coordinate result channel.
interface rwts_rsp_if
   import rwts_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [9:0]          row;
   logic [1:0]          texture_index;
   logic [TEX_BITS-1:0] texel_column;
   logic [TEX_BITS-1:0] texel_row;
   logic                last;

   modport source (output valid, row, texture_index, texel_column, texel_row, last,
                   input ready);
   modport sink   (input valid, row, texture_index, texel_column, texel_row, last,
                   output ready);
endinterface

// ===== sv/raycast_wall_texture_span_core.sv =====
// Pixel tick: result registered the next cycle; one tick per cycle while no setup runs
// and the output is empty or being taken. Column setup: not ready again until the
// shared multiplier (hit coordinate, start position) and the bit-serial step divider
// (DIV_BITS (23) quotient bits) are done. Ticks with no active span give no item.
// Synchronous active-high reset: no span active, sequencer idle, output empty.
`include "raycast_wall_texture_span_core_defines.svh"
module raycast_wall_texture_span_core
   import rwts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rwts_req_if.sink    req_chan,
   rwts_rsp_if.source  rsp_chan
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MULH = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_MULP = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic                span_active_ff, span_active_in;
   logic [10:0]         cur_row_ff, cur_row_in;
   logic [10:0]         end_row_ff, end_row_in;
   logic [39:0]         pos_ff, pos_in;
   logic [23:0]         step_ff, step_in;
   logic [TEX_BITS-1:0] column_ff, column_in;
   logic [1:0]          index_ff, index_in;

   // Setup operands held across the sequence.
   logic                       mirror_ff, mirror_in;
   logic [15:0]                coord_ff, coord_in;
   logic [23:0]                dist_ff, dist_in;
   logic signed [MUL_B_W-1:0]  ray_ff, ray_in;
   logic signed [MUL_B_W-1:0]  base_ff, base_in;
   logic [15:0]                lh_ff, lh_in;
   logic [9:0]                 start_ff, start_in;
   logic [10:0]                endc_ff, endc_in;

   // Divider state.
   logic [15:0]          rem_ff, rem_in;
   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [9:0]          rsp_row_ff, rsp_row_in;
   logic [1:0]          rsp_index_ff, rsp_index_in;
   logic [TEX_BITS-1:0] rsp_column_ff, rsp_column_in;
   logic [TEX_BITS-1:0] rsp_texrow_ff, rsp_texrow_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                       req_ready;
   logic                       req_fire;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  mul_p;
   logic [15:0]                hit_frac;
   logic [TEX_BITS-1:0]        hit_col;
   logic [16:0]                div_shift;
   logic [17:0]                div_diff;
   logic                       div_ge;
   logic [11:0]                row_next;
   logic                       row_last;
   logic [15:0]                lh_fixed;
   logic                       rx_pos;
   logic                       ry_pos;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire  = req_chan.valid && req_ready;

   // Shared multiplier: hit offset, then start position.
   always_comb begin
      if (state_ff == ST_MULH) begin
         mul_a = MUL_A_W'({1'b0, dist_ff});
         mul_b = ray_ff;
      end else begin
         mul_a = MUL_A_W'({1'b0, quo_ff});
         mul_b = base_ff;
      end
   end
   assign mul_p = mul_a * mul_b;

   // Integer part of the hit coordinate drops out; keep the fraction.
   assign hit_frac = coord_ff + mul_p[31:16];
   assign hit_col  = hit_frac[15 -: TEX_BITS];

   assign div_shift = {rem_ff, DIVIDEND[div_cnt_ff]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, lh_ff};
   assign div_ge    = !div_diff[17];

   assign row_next = {1'b0, cur_row_ff} + 12'd1;
   assign row_last = row_next >= {1'b0, end_row_ff};

   assign lh_fixed = (req_chan.wall_height == 16'd0) ? 16'd1 : req_chan.wall_height;
   assign rx_pos   = !req_chan.ray_dir_x[17] && (req_chan.ray_dir_x != '0);
   assign ry_pos   = !req_chan.ray_dir_y[17] && (req_chan.ray_dir_y != '0);

   always_comb begin
      state_in       = state_ff;
      span_active_in = span_active_ff;
      cur_row_in     = cur_row_ff;
      end_row_in     = end_row_ff;
      pos_in         = pos_ff;
      step_in        = step_ff;
      column_in      = column_ff;
      index_in       = index_ff;
      mirror_in      = mirror_ff;
      coord_in       = coord_ff;
      dist_in        = dist_ff;
      ray_in         = ray_ff;
      base_in        = base_ff;
      lh_in          = lh_ff;
      start_in       = start_ff;
      endc_in        = endc_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_row_in     = rsp_row_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_column_in  = rsp_column_ff;
      rsp_texrow_in  = rsp_texrow_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_chan.kind == KIND_TICK) begin
               if (span_active_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_row_in    = cur_row_ff[9:0];
                  rsp_index_in  = index_ff;
                  rsp_column_in = column_ff;
                  rsp_texrow_in = pos_ff[16 +: TEX_BITS];
                  rsp_last_in   = row_last;
                  pos_in        = pos_ff + {16'd0, step_ff};
                  cur_row_in    = row_next[10:0];
                  if (row_last) begin
                     span_active_in = 1'b0;
                  end
               end
            end else if (req_fire) begin
               // Latch the column; the hit axis is the one across the face.
               if (req_chan.side == SIDE_X) begin
                  coord_in  = req_chan.pos_y[15:0];
                  ray_in    = req_chan.ray_dir_y;
                  mirror_in = rx_pos;
                  index_in  = rx_pos ? TEX_X_POS : TEX_X_NEG;
               end else begin
                  coord_in  = req_chan.pos_x[15:0];
                  ray_in    = req_chan.ray_dir_x;
                  mirror_in = req_chan.ray_dir_y[17];
                  index_in  = ry_pos ? TEX_Y_POS : TEX_Y_NEG;
               end
               dist_in  = req_chan.wall_distance;
               lh_in    = lh_fixed;
               base_in  = MUL_B_W'({8'd0, req_chan.span_start})
                        - MUL_B_W'(HALF_ROWS)
                        + MUL_B_W'({1'b0, lh_fixed[15:1]});
               start_in = req_chan.span_start;
               endc_in  = (req_chan.span_end > 11'(SCREEN_ROWS)) ? 11'(SCREEN_ROWS)
                                                                 : req_chan.span_end;
               state_in = ST_MULH;
            end
         end
         ST_MULH: begin
            column_in  = mirror_ff ? ~hit_col : hit_col;
            rem_in     = '0;
            quo_in     = '0;
            div_cnt_in = DIV_CNT_W'(DIV_BITS - 1);
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // One quotient bit per cycle, restoring.
            rem_in = div_ge ? div_diff[15:0] : div_shift[15:0];
            quo_in = {quo_ff[DIV_BITS-2:0], div_ge};
            if (div_cnt_ff == '0) begin
               state_in = ST_MULP;
            end else begin
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         ST_MULP: begin
            // Quotient never exceeds 2^22, so the 24-bit step needs no clamp.
            step_in        = 24'(quo_ff);
            pos_in         = mul_p[39:0];
            cur_row_in     = {1'b0, start_ff};
            end_row_in     = endc_ff;
            span_active_in = {1'b0, start_ff} < endc_ff;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         span_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         div_cnt_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         span_active_ff <= span_active_in;
         rsp_valid_ff   <= rsp_valid_in;
         div_cnt_ff     <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_row_ff    <= cur_row_in;
      end_row_ff    <= end_row_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      column_ff     <= column_in;
      index_ff      <= index_in;
      mirror_ff     <= mirror_in;
      coord_ff      <= coord_in;
      dist_ff       <= dist_in;
      ray_ff        <= ray_in;
      base_ff       <= base_in;
      lh_ff         <= lh_in;
      start_ff      <= start_in;
      endc_ff       <= endc_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_column_ff <= rsp_column_in;
      rsp_texrow_ff <= rsp_texrow_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_chan.ready         = req_ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.row           = rsp_row_ff;
   assign rsp_chan.texture_index = rsp_index_ff;
   assign rsp_chan.texel_column  = rsp_column_ff;
   assign rsp_chan.texel_row     = rsp_texrow_ff;
   assign rsp_chan.last          = rsp_last_ff;

   `RWTS_ASSERT_NEXT(a_setup_blocks, req_fire && req_chan.kind == KIND_SETUP, !req_chan.ready)
   `RWTS_ASSERT_IMPLY(a_span_in_range, span_active_ff, cur_row_ff < end_row_ff)
   `RWTS_ASSERT_IMPLY(a_step_nonzero, span_active_ff, step_ff != '0)
   `RWTS_ASSERT_IMPLY(a_rsp_from_tick, $rose(rsp_valid_ff), $past(req_fire && req_chan.kind == KIND_TICK))

endmodule

// ===== bench/raycast_wall_texture_span_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking regression for the raycast wall texture span core.
module raycast_wall_texture_span_core_test;
   import rwts_pkg::*;

   localparam int     RANDOM_ITEMS  = 1500;
   localparam int     STALL_MAX     = 16;
   localparam int     IDLE_LIMIT    = 4000;
   localparam int     SETTLE_CYCLES = 40;
   localparam int     DRAIN_EVERY   = 400;
   localparam longint STEP_LIMIT    = 64'h0000_0000_00FF_FFFF;

   typedef struct {
      logic               kind;
      logic               side;
      logic [23:0]        pos_x;
      logic [23:0]        pos_y;
      logic signed [17:0] ray_dir_x;
      logic signed [17:0] ray_dir_y;
      logic [23:0]        wall_distance;
      logic [15:0]        wall_height;
      logic [9:0]         span_start;
      logic [10:0]        span_end;
   } span_req_type;

   typedef struct {
      logic [9:0]          row;
      logic [1:0]          texture_index;
      logic [TEX_BITS-1:0] texel_column;
      logic [TEX_BITS-1:0] texel_row;
      logic                last;
   } texel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rwts_req_if req_chan();
   rwts_rsp_if rsp_chan();

   raycast_wall_texture_span_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 0;
   end

   texel_type predicted_texels[$];
   int        fail_count = 0;
   int        sent_count = 0;
   bit        no_idle    = 1'b0;

   // Column state as the block should hold it.
   bit                  col_active        = 1'b0;
   logic [10:0]         col_row           = '0;
   logic [10:0]         col_end           = '0;
   logic [39:0]         col_pos           = '0;
   logic [23:0]         col_step          = '0;
   logic [TEX_BITS-1:0] col_texel_column  = '0;
   logic [1:0]          col_texture_index = '0;

   function automatic void latch_column(input span_req_type r);
      longint              prod;
      longint              lh;
      longint              step;
      longint              base;
      logic [31:0]         hit;
      logic [TEX_BITS-1:0] column;
      logic [10:0]         span_end;
      if (r.side == SIDE_X)
         prod = longint'(r.wall_distance) * longint'(r.ray_dir_y);
      else
         prod = longint'(r.wall_distance) * longint'(r.ray_dir_x);
      if (r.side == SIDE_X)
         hit = {r.pos_y[15:0], 16'h0000} + prod[31:0];
      else
         hit = {r.pos_x[15:0], 16'h0000} + prod[31:0];
      column = hit[31 -: TEX_BITS];
      if ((r.side == SIDE_X && r.ray_dir_x > 0) || (r.side == SIDE_Y && r.ray_dir_y < 0))
         column = TEX_BITS'(TEXTURE_SIZE - 1) - column;
      col_texel_column = column;
      if (r.side == SIDE_X)
         col_texture_index = (r.ray_dir_x > 0) ? TEX_X_POS : TEX_X_NEG;
      else
         col_texture_index = (r.ray_dir_y > 0) ? TEX_Y_POS : TEX_Y_NEG;

      lh = (r.wall_height == 16'd0) ? 64'sd1 : longint'(r.wall_height);
      step = (longint'(TEXTURE_SIZE) << 16) / lh;
      if (step > STEP_LIMIT)
         step = STEP_LIMIT;
      col_step = 24'(step);

      // Floor semantics fall out of two's complement for rows above the center.
      base = longint'(r.span_start) - longint'(HALF_ROWS) + lh / 2;
      col_pos = 40'(base * step);

      span_end = (r.span_end > 11'(SCREEN_ROWS)) ? 11'(SCREEN_ROWS) : r.span_end;
      col_row = {1'b0, r.span_start};
      col_end = span_end;
      col_active = ({1'b0, r.span_start} < span_end);
   endfunction

   function automatic bit advance_pixel(output texel_type t);
      bit last;
      last = (int'(col_row) + 1) >= int'(col_end);
      t.row           = col_row[9:0];
      t.texture_index = col_texture_index;
      t.texel_column  = col_texel_column;
      t.texel_row     = col_pos[16 +: TEX_BITS];
      t.last          = last;
      if (!col_active)
         return 1'b0;
      col_pos = col_pos + 40'(col_step);
      col_row = col_row + 11'd1;
      if (last)
         col_active = 1'b0;
      return 1'b1;
   endfunction

   function automatic span_req_type random_item(input logic kind);
      span_req_type r;
      r.kind          = kind;
      r.side          = 1'($urandom_range(0, 1));
      r.pos_x         = 24'($urandom);
      r.pos_y         = 24'($urandom);
      r.ray_dir_x     = 18'($urandom);
      r.ray_dir_y     = 18'($urandom);
      r.wall_distance = 24'($urandom);
      r.wall_height   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 64))
                                                    : 16'($urandom);
      r.span_start    = 10'($urandom);
      r.span_end      = 11'($urandom_range(0, 2047));
      return r;
   endfunction

   function automatic span_req_type column_item(input logic side,
                                                input logic [23:0] pos_x,
                                                input logic [23:0] pos_y,
                                                input logic signed [17:0] ray_dir_x,
                                                input logic signed [17:0] ray_dir_y,
                                                input logic [23:0] wall_distance,
                                                input logic [15:0] wall_height,
                                                input logic [9:0] span_start,
                                                input logic [10:0] span_end);
      span_req_type r;
      r.kind          = KIND_SETUP;
      r.side          = side;
      r.pos_x         = pos_x;
      r.pos_y         = pos_y;
      r.ray_dir_x     = ray_dir_x;
      r.ray_dir_y     = ray_dir_y;
      r.wall_distance = wall_distance;
      r.wall_height   = wall_height;
      r.span_start    = span_start;
      r.span_end      = span_end;
      return r;
   endfunction

   task automatic drive_fields(input span_req_type r);
      req_chan.kind          = r.kind;
      req_chan.side          = r.side;
      req_chan.pos_x         = r.pos_x;
      req_chan.pos_y         = r.pos_y;
      req_chan.ray_dir_x     = r.ray_dir_x;
      req_chan.ray_dir_y     = r.ray_dir_y;
      req_chan.wall_distance = r.wall_distance;
      req_chan.wall_height   = r.wall_height;
      req_chan.span_start    = r.span_start;
      req_chan.span_end      = r.span_end;
   endtask

   // Valid stays high after an accept; the next call either reuses the slot or drops it.
   task automatic send_item(input span_req_type r);
      int        gap;
      texel_type t;
      gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      drive_fields(r);
      req_chan.valid = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
      if (r.kind == KIND_SETUP)
         latch_column(r);
      else if (advance_pixel(t))
         predicted_texels.push_back(t);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_item(random_item(KIND_TICK));
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (predicted_texels.size() != 0) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input int unsigned exp_val,
                                       input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_val, act_val);
         fail_count++;
      end
   endfunction

   // Result side: stall, take one item, compare with the oldest prediction.
   initial begin
      int        stall;
      texel_type e;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, STALL_MAX);
         if (stall > 0) begin
            @(negedge clock);
            rsp_chan.ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_chan.ready = 1'b1;
         @(posedge clock);
         while (rsp_chan.valid !== 1'b1) @(posedge clock);
         if (predicted_texels.size() == 0) begin
            $display("%0t ns: texel item with none predicted, expected nothing, got row %0d",
                     $time, rsp_chan.row);
            fail_count++;
         end else begin
            e = predicted_texels.pop_front();
            check_field("row", e.row, rsp_chan.row);
            check_field("texture_index", e.texture_index, rsp_chan.texture_index);
            check_field("texel_column", e.texel_column, rsp_chan.texel_column);
            check_field("texel_row", e.texel_row, rsp_chan.texel_row);
            check_field("last", e.last, rsp_chan.last);
         end
      end
   end

   // Watchdog: end the run when no item moves for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("raycast_wall_texture_span_core regression: fail");
      $finish;
   end

   task automatic test_idle_ticks();
      send_ticks(1);
   endtask

   task automatic test_field_extremes();
      send_item(column_item(SIDE_X, 24'hFFFFFF, 24'hFFFFFF, 18'sh1FFFF, 18'sh20000,
                            24'hFFFFFF, 16'hFFFF, 10'd0, 11'd1024));
      send_ticks(2);
      // Span end past the screen clamps, leaving a single row.
      send_item(column_item(SIDE_Y, 24'h000000, 24'h000000, 18'sh20000, 18'sh1FFFF,
                            24'h000000, 16'd1, 10'd767, 11'd2047));
      send_ticks(2);
   endtask

   task automatic test_mirror_faces();
      send_item(column_item(SIDE_X, 24'h012345, 24'h03A5C3, 18'sh00000, 18'sh0C000,
                            24'h018000, 16'd64, 10'd200, 11'd201));
      send_ticks(1);
      send_item(column_item(SIDE_X, 24'h012345, 24'h03A5C3, 18'sh08000, 18'sh3C000,
                            24'h018000, 16'd64, 10'd200, 11'd201));
      send_ticks(1);
      send_item(column_item(SIDE_Y, 24'h0B7E21, 24'h012345, 18'sh31000, 18'sh30000,
                            24'h00C000, 16'd64, 10'd200, 11'd201));
      send_ticks(1);
      send_item(column_item(SIDE_Y, 24'h0B7E21, 24'h012345, 18'sh07000, 18'sh10000,
                            24'h00C000, 16'd64, 10'd200, 11'd201));
      send_ticks(1);
   endtask

   task automatic test_height_limits();
      // Zero height acts as one.
      send_item(column_item(SIDE_X, 24'h020000, 24'h028000, 18'sh10000, 18'sh10000,
                            24'h010000, 16'd0, 10'd100, 11'd103));
      send_ticks(1);
      // Rows far above center start at a negative position.
      send_item(column_item(SIDE_Y, 24'h024000, 24'h020000, 18'sh3F000, 18'sh00100,
                            24'h020000, 16'd3, 10'd0, 11'd4));
      send_ticks(1);
   endtask

   task automatic test_empty_spans();
      send_item(column_item(SIDE_X, 24'h010000, 24'h010000, 18'sh10000, 18'sh00000,
                            24'h010000, 16'd100, 10'd500, 11'd500));
      send_item(column_item(SIDE_Y, 24'h010000, 24'h010000, 18'sh10000, 18'sh10000,
                            24'h010000, 16'd100, 10'd1023, 11'd1024));
      send_ticks(1);
   endtask

   task automatic test_replace_span();
      send_item(column_item(SIDE_X, 24'h054321, 24'h0ABCDE, 18'sh2A000, 18'sh05000,
                            24'h030000, 16'd200, 10'd10, 11'd20));
      send_ticks(2);
      send_item(column_item(SIDE_Y, 24'h0FEDCB, 24'h012121, 18'sh0F000, 18'sh32000,
                            24'h008000, 16'd700, 10'd50, 11'd52));
      send_ticks(3);
      wait_for_drain();
   endtask

   task automatic test_random_spans();
      int           first_count;
      int           next_drain;
      int           mode;
      int           len;
      int           ticks;
      span_req_type r;
      first_count = sent_count;
      next_drain  = sent_count + DRAIN_EVERY;
      while (sent_count - first_count < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 7) == 0);
         mode = $urandom_range(0, 9);
         if (mode <= 6) begin
            r = random_item(KIND_SETUP);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            r.span_start = 10'($urandom_range(0, SCREEN_ROWS - 1));
            r.span_end   = 11'(int'(r.span_start) + len);
            send_item(r);
            ticks = len + int'($urandom_range(0, 2));
            // Sometimes cut the span short so the next setup replaces it.
            if ($urandom_range(0, 5) == 0)
               ticks = int'($urandom_range(0, len));
            send_ticks(ticks);
         end else if (mode == 7) begin
            send_item(random_item(KIND_SETUP));
            send_ticks($urandom_range(0, 4));
         end else begin
            send_ticks($urandom_range(1, 4));
         end
         if (sent_count >= next_drain) begin
            wait_for_drain();
            next_drain = sent_count + DRAIN_EVERY;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      span_req_type blank;
      blank = column_item(SIDE_X, '0, '0, '0, '0, '0, '0, '0, '0);
      drive_fields(blank);
      req_chan.valid = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_ticks();
      test_field_extremes();
      test_mirror_faces();
      test_height_limits();
      test_empty_spans();
      test_replace_span();
      test_random_spans();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && predicted_texels.size() == 0)
         $display("raycast_wall_texture_span_core regression: pass");
      else
         $display("raycast_wall_texture_span_core regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/rwts_pkg.sv
sv/rwts_req_if.sv
sv/rwts_rsp_if.sv
sv/raycast_wall_texture_span_core.sv
bench/raycast_wall_texture_span_core_test.sv
